>>> sv/itot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itot_pkg;

   // table geometry
   localparam int ENTRIES_PER_TABLE = 32;
   localparam int SECTOR_BYTES      = 128;
   localparam int SECTOR_COUNT      = 1024;
   localparam int MAX_LEVELS        = 4;

   // field widths
   localparam int OFFSET_W   = 27;
   localparam int SECTOR_W   = 10;
   localparam int SLOT_W     = $clog2(ENTRIES_PER_TABLE);
   localparam int ENTRY_W    = 11;
   localparam int LEVEL_W    = 3;
   localparam int STATUS_W   = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;

   // derived sizes
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
   localparam int INDEX_W      = OFFSET_W - SECTOR_SHIFT;
   localparam int PATH_W       = MAX_LEVELS * SLOT_W;
   localparam int ADDR_W       = SECTOR_W + SLOT_W;
   localparam int STORE_DEPTH  = SECTOR_COUNT * ENTRIES_PER_TABLE;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROOT_SECTOR = 1'b0,
      CSR_LEVEL_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_WRITE     = 1'b0,
      MODE_TRANSLATE = 1'b1
   } mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

`default_nettype wire

>>> sv/indirect_table_offset_translate.sv
`timescale 1ns / 1ps
`default_nettype none

// indirect sector table walk: byte offset to data sector
//
// req channel (valid/stall): mode 0 writes one pointer entry of the table store,
// mode 1 translates byte_offset. a transfer happens when req_valid is high and
// req_stall is low. rsp channel (valid/stall) carries one result per translate,
// none per write. csr channel (valid/ready) writes root_sector and level_count.
// a write is done at its transfer and leaves the block idle. a translate walks
// L levels, L being the clamped level count (1..4), each level one dependent
// read of the single store memory whose read data is registered before the
// next address is formed; a range error or a bad root goes straight to done.
// one item is worked on at a time; after a translate the next one is taken
// as soon as the result has moved into the rsp register, even while that
// register waits on rsp_stall.
// reset: after reset falls the store is swept to all ones (empty), one entry a
// cycle, all 32768 entries; req_stall stays high meanwhile, csr writes are taken.
// a stalled receiver holds the rsp register; a finished walk then waits in its
// done state and req_stall stays high until the result can move on.

module indirect_table_offset_translate (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_mode,
   input  wire logic [itot_pkg::OFFSET_W-1:0]         req_byte_offset,
   input  wire logic [itot_pkg::SECTOR_W-1:0]         req_table_sector,
   input  wire logic [itot_pkg::SLOT_W-1:0]           req_table_slot,
   input  wire logic signed [itot_pkg::ENTRY_W-1:0]   req_entry_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [itot_pkg::SECTOR_W-1:0]              rsp_data_sector,
   output logic [itot_pkg::STATUS_W-1:0]              rsp_status,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [itot_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [itot_pkg::CSR_DATA_W-1:0]       csr_data
);

   // table store, one synchronous memory
   logic [itot_pkg::ENTRY_W-1:0] store_mem [itot_pkg::STORE_DEPTH];
   logic [itot_pkg::ENTRY_W-1:0] rd_data_ff;
   logic [itot_pkg::ADDR_W-1:0]  rd_addr;
   logic [itot_pkg::ADDR_W-1:0]  wr_addr;
   logic [itot_pkg::ENTRY_W-1:0] wr_data;
   logic                         wr_en;

   // control state
   itot_pkg::state_type           state_ff, state_in;
   logic [itot_pkg::ADDR_W-1:0]   clr_ff, clr_in;
   logic [itot_pkg::PATH_W-1:0]   path_ff, path_in;
   logic [itot_pkg::LEVEL_W-1:0]  left_ff, left_in;
   logic [itot_pkg::SECTOR_W-1:0] result_ff, result_in;
   itot_pkg::status_type          status_ff, status_in;

   // configuration registers
   logic [itot_pkg::SECTOR_W-1:0] root_ff;
   logic [itot_pkg::LEVEL_W-1:0]  levels_ff;

   // rsp register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [itot_pkg::SECTOR_W-1:0] rsp_sector_ff, rsp_sector_in;
   itot_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic                          req_xfer;
   logic                          rsp_free;
   logic [itot_pkg::LEVEL_W-1:0]  levels_eff;
   logic [itot_pkg::INDEX_W-1:0]  req_index;
   logic [itot_pkg::PATH_W-1:0]   req_path;
   logic                          out_of_range;
   logic                          root_bad;
   logic                          entry_bad;

   assign req_stall = reset || (state_ff != itot_pkg::ST_IDLE);
   assign csr_ready = !reset;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_sector = rsp_sector_ff;
   assign rsp_status      = rsp_status_ff;

   // level count of 0 walks one level, above the maximum walks the maximum
   always_comb begin
      if (levels_ff == '0) begin
         levels_eff = itot_pkg::LEVEL_W'(1);
      end else if (32'(levels_ff) > itot_pkg::MAX_LEVELS) begin
         levels_eff = itot_pkg::LEVEL_W'(itot_pkg::MAX_LEVELS);
      end else begin
         levels_eff = levels_ff;
      end
   end

   // sector index, and its digits aligned so the top slot field picks the entry
   assign req_index    = req_byte_offset[itot_pkg::OFFSET_W-1:itot_pkg::SECTOR_SHIFT];
   assign out_of_range = (req_index >> (itot_pkg::SLOT_W * 32'(levels_eff))) != '0;
   assign req_path     = itot_pkg::PATH_W'(req_index)
                         << (itot_pkg::SLOT_W * (itot_pkg::MAX_LEVELS - 32'(levels_eff)));

   // sign bit marks an empty pointer, a sector past the disk is treated alike
   assign root_bad  = 32'(root_ff) >= itot_pkg::SECTOR_COUNT;
   assign entry_bad = rd_data_ff[itot_pkg::ENTRY_W-1]
                      || (32'(rd_data_ff[itot_pkg::ENTRY_W-2:0]) >= itot_pkg::SECTOR_COUNT);

   // read address: root table on a translate transfer, else the pointer just read
   always_comb begin
      if (state_ff == itot_pkg::ST_WALK) begin
         rd_addr = {rd_data_ff[itot_pkg::SECTOR_W-1:0],
                    path_ff[itot_pkg::PATH_W-1 -: itot_pkg::SLOT_W]};
      end else begin
         rd_addr = {root_ff, req_path[itot_pkg::PATH_W-1 -: itot_pkg::SLOT_W]};
      end
   end

   // write port: clearing sweep, or an entry write transfer
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '1;
      if (state_ff == itot_pkg::ST_CLEAR) begin
         wr_en = 1'b1;
      end else if (req_xfer && (req_mode == itot_pkg::MODE_WRITE)) begin
         wr_en   = (32'(req_table_sector) < itot_pkg::SECTOR_COUNT)
                   && (32'(req_table_slot) < itot_pkg::ENTRIES_PER_TABLE);
         wr_addr = {req_table_sector, req_table_slot};
         wr_data = req_entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // walk sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      path_in   = path_ff;
      left_in   = left_ff;
      result_in = result_ff;
      status_in = status_ff;
      unique case (state_ff)
         itot_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == itot_pkg::ADDR_W'(itot_pkg::STORE_DEPTH - 1)) begin
               state_in = itot_pkg::ST_IDLE;
            end
         end
         itot_pkg::ST_IDLE: begin
            if (req_xfer && (req_mode == itot_pkg::MODE_TRANSLATE)) begin
               result_in = '0;
               if (out_of_range) begin
                  status_in = itot_pkg::STATUS_RANGE;
                  state_in  = itot_pkg::ST_DONE;
               end else if (root_bad) begin
                  status_in = itot_pkg::STATUS_EMPTY;
                  state_in  = itot_pkg::ST_DONE;
               end else begin
                  // first read issued now, the rest follow one per cycle
                  path_in  = req_path << itot_pkg::SLOT_W;
                  left_in  = levels_eff - 1'b1;
                  state_in = itot_pkg::ST_WALK;
               end
            end
         end
         itot_pkg::ST_WALK: begin
            if (entry_bad) begin
               result_in = '0;
               status_in = itot_pkg::STATUS_EMPTY;
               state_in  = itot_pkg::ST_DONE;
            end else if (left_ff == '0) begin
               result_in = rd_data_ff[itot_pkg::SECTOR_W-1:0];
               status_in = itot_pkg::STATUS_OK;
               state_in  = itot_pkg::ST_DONE;
            end else begin
               path_in = path_ff << itot_pkg::SLOT_W;
               left_in = left_ff - 1'b1;
            end
         end
         itot_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = itot_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itot_pkg::ST_IDLE;
         end
      endcase
   end

   // rsp register loads from the done state when it is free
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sector_in = rsp_sector_ff;
      rsp_status_in = rsp_status_ff;
      if ((state_ff == itot_pkg::ST_DONE) && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_sector_in = result_ff;
         rsp_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itot_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      path_ff       <= path_in;
      left_ff       <= left_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      rsp_sector_ff <= rsp_sector_in;
      rsp_status_ff <= rsp_status_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff   <= '0;
         levels_ff <= itot_pkg::LEVEL_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            itot_pkg::CSR_ROOT_SECTOR: root_ff   <= csr_data[itot_pkg::SECTOR_W-1:0];
            itot_pkg::CSR_LEVEL_COUNT: levels_ff <= csr_data[itot_pkg::LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> sv/itot_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module itot_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              req_mode,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [itot_pkg::SECTOR_W-1:0]     rsp_data_sector,
   input wire logic [itot_pkg::STATUS_W-1:0]     rsp_status
);

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // store sweep keeps requests off right after reset
   a_clear_stall: assert property (@(posedge clock) $fell(reset) |-> req_stall)
      else $error("request taken during store clear");

   // one translate at a time
   a_busy_after_translate: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_mode == itot_pkg::MODE_TRANSLATE)) |=> req_stall)
      else $error("request taken while a walk runs");

   // errors report sector zero
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != itot_pkg::STATUS_OK)) |-> (rsp_data_sector == '0))
      else $error("nonzero sector on error status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_data_sector) && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind indirect_table_offset_translate itot_checker u_itot_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_mode        (req_mode),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_data_sector (rsp_data_sector),
   .rsp_status      (rsp_status)
);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // no-transfer cycles allowed; covers the store sweep after reset
   localparam int WATCHDOG_LIMIT = 100000;
   // quiet cycles before a csr write, longer than a four-level walk plus a write
   localparam int IDLE_GUARD     = 8;
   localparam int TAIL_CYCLES    = 16;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 155;
   localparam int TOP_OFFSET     = 2 ** itot_pkg::OFFSET_W - 1;
   // bytes mapped by one full table at a single level
   localparam int TABLE_SPAN     = itot_pkg::ENTRIES_PER_TABLE * itot_pkg::SECTOR_BYTES;

   typedef struct {
      itot_pkg::mode_type                   mode;
      logic [itot_pkg::OFFSET_W-1:0]        offset;
      logic [itot_pkg::SECTOR_W-1:0]        sector;
      logic [itot_pkg::SLOT_W-1:0]          slot;
      logic signed [itot_pkg::ENTRY_W-1:0]  value;
   } request_type;

   typedef struct {
      logic [itot_pkg::SECTOR_W-1:0] data_sector;
      itot_pkg::status_type          status;
   } lookup_type;

   typedef enum {ROW_ITEM, ROW_CSR} row_kind_type;

   // one line of the directed script
   typedef struct {
      row_kind_type                     kind;
      request_type                      item;
      itot_pkg::csr_index_type          csr_idx;
      logic [itot_pkg::CSR_DATA_W-1:0]  csr_value;
      bit                               typed;
      lookup_type                       want;
   } script_row_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic                                 req_mode = 1'b0;
   logic [itot_pkg::OFFSET_W-1:0]        req_byte_offset = '0;
   logic [itot_pkg::SECTOR_W-1:0]        req_table_sector = '0;
   logic [itot_pkg::SLOT_W-1:0]          req_table_slot = '0;
   logic signed [itot_pkg::ENTRY_W-1:0]  req_entry_value = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [itot_pkg::SECTOR_W-1:0]        rsp_data_sector;
   logic [itot_pkg::STATUS_W-1:0]        rsp_status;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [itot_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [itot_pkg::CSR_DATA_W-1:0]      csr_data = '0;

   // mirror of the table store and of both registers
   logic [itot_pkg::ENTRY_W-1:0]   sector_tables [itot_pkg::STORE_DEPTH];
   logic [itot_pkg::SECTOR_W-1:0]  root_copy;
   logic [itot_pkg::LEVEL_W-1:0]   levels_copy;

   // translations accepted whose result has not come back yet
   lookup_type      pending_lookups[$];
   lookup_type      no_want;
   script_row_type  script[$];

   int mismatches  = 0;
   int idle_cycles = 0;
   int burst_left  = 0;
   int stall_style = 0;
   int stall_left  = 0;

   indirect_table_offset_translate u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_byte_offset (req_byte_offset),
      .req_table_sector(req_table_sector),
      .req_table_slot  (req_table_slot),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_sector (rsp_data_sector),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // level register: zero acts as one, above the maximum acts as the maximum
   function automatic int walk_depth(input logic [itot_pkg::LEVEL_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > itot_pkg::MAX_LEVELS) return itot_pkg::MAX_LEVELS;
      return int'(raw);
   endfunction

   // slot picked at level lv, most significant digit first
   function automatic logic [itot_pkg::SLOT_W-1:0] level_digit(
      input logic [itot_pkg::INDEX_W-1:0] idx, input int lv, input int depth);
      logic [itot_pkg::INDEX_W-1:0] shifted;
      shifted = idx >> (itot_pkg::SLOT_W * (depth - 1 - lv));
      return shifted[itot_pkg::SLOT_W-1:0];
   endfunction

   function automatic lookup_type translate_offset(
      input logic [itot_pkg::OFFSET_W-1:0] offset);
      logic [itot_pkg::INDEX_W-1:0]   idx;
      logic [itot_pkg::ENTRY_W-1:0]   raw;
      logic [itot_pkg::SECTOR_W-1:0]  cur;
      int                             depth;
      lookup_type                     res;
      idx = offset[itot_pkg::OFFSET_W-1:itot_pkg::SECTOR_SHIFT];
      depth = walk_depth(levels_copy);
      cur = root_copy;
      res.data_sector = '0;
      res.status = itot_pkg::STATUS_OK;
      // a 10-bit root always names a real sector, so only the range is checked up front
      if ((idx >> (itot_pkg::SLOT_W * depth)) != 0) begin
         res.status = itot_pkg::STATUS_RANGE;
      end else begin
         for (int lv = 0; lv < depth; lv++) begin
            raw = sector_tables[{cur, level_digit(idx, lv, depth)}];
            // sign bit means empty; an 11-bit positive can never reach the sector count
            if (raw[itot_pkg::ENTRY_W-1]) begin
               res.status = itot_pkg::STATUS_EMPTY;
               break;
            end
            cur = raw[itot_pkg::SECTOR_W-1:0];
         end
         if (res.status == itot_pkg::STATUS_OK) res.data_sector = cur;
      end
      return res;
   endfunction

   // every field random, the caller narrows what matters
   function automatic request_type random_request(input itot_pkg::mode_type mode);
      request_type it;
      it.mode = mode;
      it.offset = itot_pkg::OFFSET_W'($urandom);
      it.sector = itot_pkg::SECTOR_W'($urandom);
      it.slot = itot_pkg::SLOT_W'($urandom);
      it.value = itot_pkg::ENTRY_W'($urandom);
      return it;
   endfunction

   // one request transfer; the sender runs in bursts with gaps between them
   task automatic send_req(input request_type it, input bit typed, input lookup_type want);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 8);
      end
      req_mode = it.mode;
      req_byte_offset = it.offset;
      req_table_sector = it.sector;
      req_table_slot = it.slot;
      req_entry_value = it.value;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // transfer taken at this edge: update the mirror or queue the expected result
      if (it.mode == itot_pkg::MODE_WRITE) begin
         sector_tables[{it.sector, it.slot}] = it.value;
      end else if (typed) begin
         pending_lookups.push_back(want);
      end else begin
         pending_lookups.push_back(translate_offset(it.offset));
      end
      burst_left--;
      @(negedge clock);
   endtask

   // hold the sender until every result is back and the block has gone quiet
   task automatic drain_block();
      req_valid = 1'b0;
      burst_left = 0;
      while (pending_lookups.size() != 0) @(negedge clock);
      repeat (IDLE_GUARD) @(negedge clock);
   endtask

   task automatic csr_write(input itot_pkg::csr_index_type idx,
                            input logic [itot_pkg::CSR_DATA_W-1:0] value);
      csr_index = idx;
      csr_data = value;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == itot_pkg::CSR_ROOT_SECTOR) root_copy = value[itot_pkg::SECTOR_W-1:0];
      else levels_copy = value[itot_pkg::LEVEL_W-1:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // writes a full chain of pointers from the root down to a random data sector
   task automatic build_path(output logic [itot_pkg::INDEX_W-1:0] idx);
      request_type                    it;
      logic [itot_pkg::SECTOR_W-1:0]  cur;
      int                             depth;
      depth = walk_depth(levels_copy);
      idx = itot_pkg::INDEX_W'($urandom & ((1 << (itot_pkg::SLOT_W * depth)) - 1));
      cur = root_copy;
      for (int lv = 0; lv < depth; lv++) begin
         it = random_request(itot_pkg::MODE_WRITE);
         it.sector = cur;
         it.slot = level_digit(idx, lv, depth);
         it.value = itot_pkg::ENTRY_W'($urandom_range(0, itot_pkg::SECTOR_COUNT - 1));
         send_req(it, 1'b0, no_want);
         cur = it.value[itot_pkg::SECTOR_W-1:0];
      end
   endtask

   task automatic add_translate(input int offset, input bit typed,
                                input int sector, input itot_pkg::status_type status);
      script_row_type row;
      row.kind = ROW_ITEM;
      row.item = random_request(itot_pkg::MODE_TRANSLATE);
      row.item.offset = itot_pkg::OFFSET_W'(offset);
      row.typed = typed;
      row.want.data_sector = itot_pkg::SECTOR_W'(sector);
      row.want.status = status;
      script.push_back(row);
   endtask

   task automatic add_write(input int sector, input int slot, input int value);
      script_row_type row;
      row.kind = ROW_ITEM;
      row.item = random_request(itot_pkg::MODE_WRITE);
      row.item.sector = itot_pkg::SECTOR_W'(sector);
      row.item.slot = itot_pkg::SLOT_W'(slot);
      row.item.value = itot_pkg::ENTRY_W'(value);
      row.typed = 1'b0;
      script.push_back(row);
   endtask

   task automatic add_csr(input itot_pkg::csr_index_type idx, input int value);
      script_row_type row;
      row.kind = ROW_CSR;
      row.csr_idx = idx;
      row.csr_value = itot_pkg::CSR_DATA_W'(value);
      script.push_back(row);
   endtask

   // receiver stall: styles of random length, from never stalling to mostly stalled
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 300);
      end
      stall_left--;
      case (stall_style)
         0: begin
            rsp_stall = 1'b0;
         end
         1: begin
            rsp_stall = ($urandom_range(0, 3) == 0);
         end
         2: begin
            rsp_stall = ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall = ~rsp_stall;
         end
      endcase
   end

   // result checking and watchdog
   always @(posedge clock) begin
      lookup_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lookups.size() == 0) begin
            $error("unexpected result transfer: data_sector %0d status %0d",
                   rsp_data_sector, rsp_status);
            mismatches++;
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_data_sector !== want.data_sector) begin
               $error("data_sector mismatch: expected %0d, actual %0d",
                      want.data_sector, rsp_data_sector);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               mismatches++;
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      request_type                     it;
      logic [itot_pkg::INDEX_W-1:0]    idx;
      logic [itot_pkg::INDEX_W-1:0]    built[$];
      logic [itot_pkg::LEVEL_W-1:0]    lvl_raw;
      logic [itot_pkg::CSR_DATA_W-1:0] word;
      int                              pick;
      int                              depth;
      int                              sent;

      for (int i = 0; i < itot_pkg::STORE_DEPTH; i++) sector_tables[i] = '1;
      root_copy = '0;
      levels_copy = itot_pkg::LEVEL_W'(1);
      no_want.data_sector = '0;
      no_want.status = itot_pkg::STATUS_OK;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed script: empty store, range limits, entry extremes, level clamping
      add_translate(0, 1'b1, 0, itot_pkg::STATUS_EMPTY);
      add_translate(TOP_OFFSET, 1'b1, 0, itot_pkg::STATUS_RANGE);
      add_translate(TABLE_SPAN, 1'b1, 0, itot_pkg::STATUS_RANGE);
      add_translate(TABLE_SPAN - 1, 1'b1, 0, itot_pkg::STATUS_EMPTY);
      add_write(0, 0, itot_pkg::SECTOR_COUNT - 1);
      add_translate(0, 1'b1, itot_pkg::SECTOR_COUNT - 1, itot_pkg::STATUS_OK);
      add_translate(itot_pkg::SECTOR_BYTES - 1, 1'b1, itot_pkg::SECTOR_COUNT - 1,
                    itot_pkg::STATUS_OK);
      add_write(0, itot_pkg::ENTRIES_PER_TABLE - 1, 0);
      add_translate(TABLE_SPAN - 1, 1'b1, 0, itot_pkg::STATUS_OK);
      // only the sign bit set still reads as empty
      add_write(itot_pkg::SECTOR_COUNT - 1, itot_pkg::ENTRIES_PER_TABLE - 1, -1024);
      add_write(itot_pkg::SECTOR_COUNT - 1, 0, 5);
      // level count of zero walks one level
      add_csr(itot_pkg::CSR_ROOT_SECTOR, itot_pkg::SECTOR_COUNT - 1);
      add_csr(itot_pkg::CSR_LEVEL_COUNT, 0);
      add_translate(TABLE_SPAN - 1, 1'b1, 0, itot_pkg::STATUS_EMPTY);
      add_translate(0, 1'b1, 5, itot_pkg::STATUS_OK);
      // all-ones register data: level count 7 clamps to four levels
      add_csr(itot_pkg::CSR_ROOT_SECTOR, 0);
      add_csr(itot_pkg::CSR_LEVEL_COUNT, 2 ** itot_pkg::CSR_DATA_W - 1);
      // last slot of sector 0 points back to sector 0 at every level
      add_translate(TOP_OFFSET, 1'b1, 0, itot_pkg::STATUS_OK);
      add_translate(0, 1'b0, 0, itot_pkg::STATUS_OK);
      add_write(0, itot_pkg::ENTRIES_PER_TABLE - 1, -1);
      add_translate(TOP_OFFSET, 1'b1, 0, itot_pkg::STATUS_EMPTY);
      add_csr(itot_pkg::CSR_LEVEL_COUNT, 2);
      add_translate(TABLE_SPAN * itot_pkg::ENTRIES_PER_TABLE, 1'b1, 0,
                    itot_pkg::STATUS_RANGE);
      add_translate(TABLE_SPAN * itot_pkg::ENTRIES_PER_TABLE - 1, 1'b1, 0,
                    itot_pkg::STATUS_EMPTY);
      add_csr(itot_pkg::CSR_LEVEL_COUNT, 3);
      add_translate(TABLE_SPAN * itot_pkg::ENTRIES_PER_TABLE * itot_pkg::ENTRIES_PER_TABLE,
                    1'b1, 0, itot_pkg::STATUS_RANGE);
      add_translate(200000, 1'b0, 0, itot_pkg::STATUS_OK);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            drain_block();
            csr_write(script[i].csr_idx, script[i].csr_value);
         end else begin
            send_req(script[i].item, script[i].typed, script[i].want);
         end
      end

      // random phases: level settings 1..7 then 0, root at both extremes and random
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain_block();
         if (ph == 0) word = '0;
         else if (ph == 3) word = itot_pkg::CSR_DATA_W'(itot_pkg::SECTOR_COUNT - 1);
         else word = itot_pkg::CSR_DATA_W'($urandom);
         csr_write(itot_pkg::CSR_ROOT_SECTOR, word);
         lvl_raw = itot_pkg::LEVEL_W'(ph + 1);
         word = itot_pkg::CSR_DATA_W'($urandom);
         word[itot_pkg::LEVEL_W-1:0] = lvl_raw;
         csr_write(itot_pkg::CSR_LEVEL_COUNT, word);
         built.delete();
         sent = 0;
         depth = walk_depth(levels_copy);
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45 || (pick < 65 && built.size() == 0)) begin
               // well-formed chain, then a lookup through it
               build_path(idx);
               built.push_back(idx);
               it = random_request(itot_pkg::MODE_TRANSLATE);
               it.offset = itot_pkg::OFFSET_W'(idx * itot_pkg::SECTOR_BYTES
                           + $urandom_range(0, itot_pkg::SECTOR_BYTES - 1));
               send_req(it, 1'b0, no_want);
               sent += depth + 1;
            end else if (pick < 65) begin
               // revisit an earlier chain, possibly overwritten since
               it = random_request(itot_pkg::MODE_TRANSLATE);
               idx = built[$urandom_range(0, built.size() - 1)];
               it.offset = itot_pkg::OFFSET_W'(idx * itot_pkg::SECTOR_BYTES
                           + $urandom_range(0, itot_pkg::SECTOR_BYTES - 1));
               send_req(it, 1'b0, no_want);
               sent++;
            end else if (pick < 75) begin
               it = random_request(itot_pkg::MODE_TRANSLATE);
               send_req(it, 1'b0, no_want);
               sent++;
            end else if (pick < 85) begin
               it = random_request(itot_pkg::MODE_TRANSLATE);
               idx = itot_pkg::INDEX_W'($urandom
                     & ((1 << (itot_pkg::SLOT_W * depth)) - 1));
               it.offset = itot_pkg::OFFSET_W'(idx * itot_pkg::SECTOR_BYTES
                           + $urandom_range(0, itot_pkg::SECTOR_BYTES - 1));
               send_req(it, 1'b0, no_want);
               sent++;
            end else if (pick < 93) begin
               it = random_request(itot_pkg::MODE_WRITE);
               send_req(it, 1'b0, no_want);
               sent++;
            end else if (pick < 98) begin
               // rewire or empty a root entry that some chain goes through
               it = random_request(itot_pkg::MODE_WRITE);
               it.sector = root_copy;
               if (built.size() != 0)
                  it.slot = level_digit(built[$urandom_range(0, built.size() - 1)], 0,
                                        depth);
               send_req(it, 1'b0, no_want);
               sent++;
            end else begin
               drain_block();
            end
         end
      end

      drain_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/itot_pkg.sv
sv/indirect_table_offset_translate.sv
sv/itot_checker.sv
tb/testbench.sv
